FILE: rtl/core/efps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efps_pkg;

    localparam int KIND_W   = 3;
    localparam int PRIO_W   = 8;
    localparam int SEL_W    = 8;
    localparam int MASK_W   = 16;
    localparam int ID_OUT_W = 4;
    localparam int EV_OUT_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR_ALL = 3'd0,
        KIND_ADD       = 3'd1,
        KIND_SET_EV    = 3'd2,
        KIND_CLR_EV    = 3'd3,
        KIND_DISPATCH  = 3'd4
    } kind_t;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/efps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module efps_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/efps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module efps_ctrl #(
    parameter int TASK_SLOTS = 16,
    parameter int EVENT_BITS = 16,
    localparam int SLOT_W  = $clog2(TASK_SLOTS),
    localparam int ENTRY_W = efps_pkg::PRIO_W + SLOT_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [efps_pkg::KIND_W-1:0]   kind,
    input  wire logic [efps_pkg::PRIO_W-1:0]   priority_in,
    input  wire logic                          handler_valid,
    input  wire logic [efps_pkg::SEL_W-1:0]    task_sel,
    input  wire logic [efps_pkg::MASK_W-1:0]   event_mask,
    output logic                               busy,
    output logic                               done,
    output logic                               status,
    output logic [efps_pkg::ID_OUT_W-1:0]      task_out,
    output logic [efps_pkg::EV_OUT_W-1:0]      events_out,
    output logic                               ord_we,
    output logic [SLOT_W-1:0]                  ord_waddr,
    output logic [ENTRY_W-1:0]                 ord_wdata,
    output logic [SLOT_W-1:0]                  ord_raddr,
    input  wire logic [ENTRY_W-1:0]            ord_rdata,
    output logic                               ev_we,
    output logic [SLOT_W-1:0]                  ev_waddr,
    output logic [EVENT_BITS-1:0]              ev_wdata,
    output logic [SLOT_W-1:0]                  ev_raddr,
    input  wire logic [EVENT_BITS-1:0]         ev_rdata
);

    localparam int CNT_W    = $clog2(TASK_SLOTS + 1);
    localparam int PRIO_W   = efps_pkg::PRIO_W;
    localparam int SEL_W    = efps_pkg::SEL_W;
    localparam int ID_OUT_W = efps_pkg::ID_OUT_W;
    localparam int EV_OUT_W = efps_pkg::EV_OUT_W;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_INS_RD  = 7'b0000010,
        ST_INS_CHK = 7'b0000100,
        ST_EV_MOD  = 7'b0001000,
        ST_SC_RD   = 7'b0010000,
        ST_SC_CHK  = 7'b0100000,
        ST_DSP_CLR = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [TASK_SLOTS-1:0]   pend_reg, pend_next;
    logic [SLOT_W-1:0]       pos_reg, pos_next;
    logic [SLOT_W-1:0]       id_reg, id_next;
    logic [PRIO_W-1:0]       prio_reg, prio_next;
    logic [EVENT_BITS-1:0]   mask_reg, mask_next;
    logic                    op_set_reg, op_set_next;
    logic                    done_reg, done_next;
    logic                    status_reg, status_next;
    logic [ID_OUT_W-1:0]     task_out_reg, task_out_next;
    logic [EV_OUT_W-1:0]     events_out_reg, events_out_next;

    logic [PRIO_W-1:0]       rd_prio;
    logic [SLOT_W-1:0]       rd_id;
    logic [EVENT_BITS-1:0]   ev_mod;

    assign rd_prio = ord_rdata[ENTRY_W-1 -: PRIO_W];
    assign rd_id   = ord_rdata[SLOT_W-1:0];
    assign ev_mod  = op_set_reg ? (ev_rdata | mask_reg) : (ev_rdata & ~mask_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pos_next        = pos_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        mask_next       = mask_reg;
        op_set_next     = op_set_reg;
        done_next       = 1'b0;
        status_next     = efps_pkg::STATUS_OK;
        task_out_next   = '0;
        events_out_next = '0;
        ord_we          = 1'b0;
        ord_waddr       = pos_reg;
        ord_wdata       = {prio_reg, id_reg};
        ord_raddr       = pos_reg - SLOT_W'(1);
        ev_we           = 1'b0;
        ev_waddr        = id_reg;
        ev_wdata        = '0;
        ev_raddr        = id_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = efps_pkg::STATUS_REJECT;
                    unique case (kind)
                        efps_pkg::KIND_CLEAR_ALL:
                        begin
                            count_next  = '0;
                            pend_next   = '0;
                            status_next = efps_pkg::STATUS_OK;
                        end
                        efps_pkg::KIND_ADD:
                        begin
                            if (handler_valid && count_reg != CNT_W'(TASK_SLOTS))
                            begin
                                done_next   = 1'b0;
                                status_next = efps_pkg::STATUS_OK;
                                id_next     = count_reg[SLOT_W-1:0];
                                pos_next    = count_reg[SLOT_W-1:0];
                                prio_next   = priority_in;
                                ev_we       = 1'b1;
                                ev_waddr    = count_reg[SLOT_W-1:0];
                                state_next  = ST_INS_RD;
                            end
                        end
                        efps_pkg::KIND_SET_EV, efps_pkg::KIND_CLR_EV:
                        begin
                            if (task_sel < SEL_W'(count_reg))
                            begin
                                done_next   = 1'b0;
                                status_next = efps_pkg::STATUS_OK;
                                id_next     = task_sel[SLOT_W-1:0];
                                ev_raddr    = task_sel[SLOT_W-1:0];
                                op_set_next = (kind == efps_pkg::KIND_SET_EV);
                                mask_next   = EVENT_BITS'(event_mask);
                                state_next  = ST_EV_MOD;
                            end
                        end
                        efps_pkg::KIND_DISPATCH:
                        begin
                            if (|pend_reg)
                            begin
                                done_next   = 1'b0;
                                status_next = efps_pkg::STATUS_OK;
                                pos_next    = '0;
                                state_next  = ST_SC_RD;
                            end
                        end
                        default:
                        begin
                            status_next = efps_pkg::STATUS_REJECT;
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    ord_we        = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    done_next     = 1'b1;
                    task_out_next = ID_OUT_W'(id_reg);
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK:
            begin
                ord_we = 1'b1;
                if (rd_prio > prio_reg)
                begin
                    ord_wdata  = ord_rdata;
                    pos_next   = pos_reg - SLOT_W'(1);
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next    = count_reg + CNT_W'(1);
                    done_next     = 1'b1;
                    task_out_next = ID_OUT_W'(id_reg);
                    state_next    = ST_IDLE;
                end
            end
            ST_EV_MOD:
            begin
                ev_we             = 1'b1;
                ev_wdata          = ev_mod;
                pend_next[id_reg] = |ev_mod;
                done_next         = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_SC_RD:
            begin
                ord_raddr  = pos_reg;
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK:
            begin
                if (pend_reg[rd_id])
                begin
                    id_next    = rd_id;
                    ev_raddr   = rd_id;
                    state_next = ST_DSP_CLR;
                end
                else
                begin
                    pos_next   = pos_reg + SLOT_W'(1);
                    state_next = ST_SC_RD;
                end
            end
            ST_DSP_CLR:
            begin
                ev_we             = 1'b1;
                pend_next[id_reg] = 1'b0;
                done_next         = 1'b1;
                task_out_next     = ID_OUT_W'(id_reg);
                events_out_next   = EV_OUT_W'(ev_rdata);
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_reg       <= '0;
            done_reg       <= 1'b0;
            status_reg     <= efps_pkg::STATUS_OK;
            task_out_reg   <= '0;
            events_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            task_out_reg   <= task_out_next;
            events_out_reg <= events_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        id_reg     <= id_next;
        prio_reg   <= prio_next;
        mask_reg   <= mask_next;
        op_set_reg <= op_set_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign task_out   = task_out_reg;
    assign events_out = events_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/event_flag_priority_scheduler_unit.sv
// Event-flag priority scheduler.
// Request channel: drive kind and its operands with start; a request is taken
// at a clock edge where start is high and busy is low. Operands are sampled
// only at that edge.
// Result channel: done pulses for one cycle with status, task_out and
// events_out. Every request gives exactly one result; the receiver must take
// it in that cycle, it cannot hold the block off.
// What each request does from the accepting edge to done:
//   clear all, any rejected request: the result follows in the next cycle
//   set events, clear events: read the task's flags, then write them back
//   add: clear the new task's flags, then walk the order list from the tail,
//        moving each listed task with a larger priority value down one place
//   dispatch: scan from the head to the first pending task, clear its flags
// One request is in flight at a time; busy stays high until the cycle in
// which done is shown. The walk over the order list, one entry per read and
// compare pair because the memory read is registered, sets the add and
// dispatch times.
// Reset empties the task table and all pending flags at once; the block takes
// a request in the first cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module event_flag_priority_scheduler_unit #(
    parameter int TASK_SLOTS = 16,
    parameter int EVENT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [efps_pkg::KIND_W-1:0]   kind,
    input  wire logic [efps_pkg::PRIO_W-1:0]   priority_in,
    input  wire logic                          handler_valid,
    input  wire logic [efps_pkg::SEL_W-1:0]    task_sel,
    input  wire logic [efps_pkg::MASK_W-1:0]   event_mask,
    output logic                               done,
    output logic                               status,
    output logic [efps_pkg::ID_OUT_W-1:0]      task_out,
    output logic [efps_pkg::EV_OUT_W-1:0]      events_out
);

    localparam int SLOT_W  = $clog2(TASK_SLOTS);
    localparam int ENTRY_W = efps_pkg::PRIO_W + SLOT_W;

    logic                  ord_we;
    logic [SLOT_W-1:0]     ord_waddr;
    logic [ENTRY_W-1:0]    ord_wdata;
    logic [SLOT_W-1:0]     ord_raddr;
    logic [ENTRY_W-1:0]    ord_rdata;
    logic                  ev_we;
    logic [SLOT_W-1:0]     ev_waddr;
    logic [EVENT_BITS-1:0] ev_wdata;
    logic [SLOT_W-1:0]     ev_raddr;
    logic [EVENT_BITS-1:0] ev_rdata;

    efps_ram #(
        .DEPTH  (TASK_SLOTS),
        .DATA_W (ENTRY_W)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    efps_ram #(
        .DEPTH  (TASK_SLOTS),
        .DATA_W (EVENT_BITS)
    ) u_event_ram (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (ev_wdata),
        .raddr (ev_raddr),
        .rdata (ev_rdata)
    );

    efps_ctrl #(
        .TASK_SLOTS (TASK_SLOTS),
        .EVENT_BITS (EVENT_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .priority_in   (priority_in),
        .handler_valid (handler_valid),
        .task_sel      (task_sel),
        .event_mask    (event_mask),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .task_out      (task_out),
        .events_out    (events_out),
        .ord_we        (ord_we),
        .ord_waddr     (ord_waddr),
        .ord_wdata     (ord_wdata),
        .ord_raddr     (ord_raddr),
        .ord_rdata     (ord_rdata),
        .ev_we         (ev_we),
        .ev_waddr      (ev_waddr),
        .ev_wdata      (ev_wdata),
        .ev_raddr      (ev_raddr),
        .ev_rdata      (ev_rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/efps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module efps_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [efps_pkg::KIND_W-1:0]   kind,
    input wire logic                          handler_valid,
    input wire logic                          done,
    input wire logic                          status,
    input wire logic [efps_pkg::ID_OUT_W-1:0] task_out,
    input wire logic [efps_pkg::EV_OUT_W-1:0] events_out
);

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in work");

    a_clear_all_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == efps_pkg::KIND_CLEAR_ALL) |=>
        (done && status == efps_pkg::STATUS_OK && task_out == '0 && events_out == '0))
        else $error("clear all did not complete in one cycle");

    a_add_no_handler: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == efps_pkg::KIND_ADD && !handler_valid) |=>
        (done && status == efps_pkg::STATUS_REJECT))
        else $error("add without handler not rejected");

    a_reject_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == efps_pkg::STATUS_REJECT) |->
        (task_out == '0 && events_out == '0))
        else $error("rejected result carries id or flags");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a request");

endmodule

bind event_flag_priority_scheduler_unit efps_checker u_efps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .handler_valid (handler_valid),
    .done          (done),
    .status        (status),
    .task_out      (task_out),
    .events_out    (events_out)
);

`default_nettype wire
